[rtl/core/pileup_feature_counter_assert.svh]
// Assertion macros for the pileup feature counter
`ifndef PILEUP_FEATURE_COUNTER_ASSERT_SVH
`define PILEUP_FEATURE_COUNTER_ASSERT_SVH

// property that holds on every clock edge outside reset
`define PFC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

`define PFC_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[rtl/core/pfc_pkg.sv]
package pfc_pkg;

	localparam int RegionLen = 16384;
	localparam int OffW = $clog2(RegionLen);
	localparam int CountW = 16;
	localparam int NumFeat = 14;
	localparam int FeatW = 4;
	localparam int FeatDepth = RegionLen * NumFeat;
	localparam int FeatAddrW = $clog2(FeatDepth);

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_CIGAR = 2'd1,
		OP_BASE = 2'd2,
		OP_READOUT = 2'd3
	} op_t;

	localparam logic [3:0] CIG_M = 4'd0;
	localparam logic [3:0] CIG_I = 4'd1;
	localparam logic [3:0] CIG_D = 4'd2;
	localparam logic [3:0] CIG_N = 4'd3;
	localparam logic [3:0] CIG_P = 4'd6;
	localparam logic [3:0] CIG_EQ = 4'd7;
	localparam logic [3:0] CIG_X = 4'd8;

	localparam logic [1:0] REG_START = 2'd0;
	localparam logic [1:0] REG_END = 2'd1;
	localparam logic [1:0] REG_MAX = 2'd2;

	localparam logic [FeatW-1:0] F_OTHER = 4'd4;
	localparam logic [FeatW-1:0] F_INS = 4'd5;
	localparam logic [FeatW-1:0] F_DEL = 4'd6;
	localparam logic [FeatW-1:0] F_COV = 4'd14;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SKIP,
		ST_CIG,
		ST_INS,
		ST_DEL,
		ST_GAP,
		ST_BASE,
		ST_RD,
		ST_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic clr_step;
		logic ld_start;
		logic ld_cigar;
		logic do_skip;
		logic upd_ins;
		logic upd_del;
		logic upd_gap;
		logic upd_base;
		logic rd_issue;
		logic out_next;
		logic stop_read;
	} pfc_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_done;
		logic active;
		logic bases_pend;
		logic past_end;
		logic gap_done;
		logic rd_done;
	} pfc_stat_t;

	function automatic logic [FeatW-1:0] feat_of(input logic [7:0] ch, input logic rev);
		logic [7:0] u;
		logic [FeatW-1:0] k;
		u = (ch >= 8'h61 && ch <= 8'h7a) ? ch - 8'd32 : ch;
		unique case (u)
			8'h41: k = 4'd0;
			8'h43: k = 4'd1;
			8'h47: k = 4'd2;
			8'h54: k = 4'd3;
			8'h49: k = F_INS;
			8'h44: k = F_DEL;
			default: k = F_OTHER;
		endcase
		return rev ? k : k + 4'd7;
	endfunction

endpackage

[rtl/core/pfc_ctrl.sv]
module pfc_ctrl import pfc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] op,
	input logic [3:0] cigar_kind,
	input logic out_stall,
	input logic out_valid,
	output pfc_cmd_t cmd,
	input pfc_stat_t stat
);

	state_t state_q, state_d;
	logic acc;

	assign in_stall = (state_q != ST_IDLE);
	assign acc = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (acc) begin
					unique case (op_t'(op))
						OP_START: cmd.ld_start = 1'b1;
						OP_CIGAR: if (stat.active) state_d = ST_SKIP;
						OP_BASE: if (stat.active && stat.bases_pend) state_d = ST_BASE;
						OP_READOUT: state_d = ST_RD;
					endcase
				end
			end
			ST_SKIP: begin
				cmd.do_skip = 1'b1;
				state_d = ST_CIG;
			end
			ST_CIG: begin
				if (!stat.active) state_d = ST_IDLE;
				else if (stat.past_end) begin
					cmd.stop_read = 1'b1;
					state_d = ST_IDLE;
				end else begin
					priority if (cigar_kind == CIG_M || cigar_kind == CIG_EQ
						|| cigar_kind == CIG_X) begin
						cmd.ld_cigar = 1'b1;
						state_d = ST_IDLE;
					end else if (cigar_kind == CIG_I) state_d = ST_INS;
					else if (cigar_kind == CIG_D || cigar_kind == CIG_N
						|| cigar_kind == CIG_P) state_d = ST_DEL;
					else state_d = ST_IDLE;
				end
			end
			ST_INS: begin
				cmd.upd_ins = 1'b1;
				state_d = ST_IDLE;
			end
			ST_DEL: begin
				cmd.upd_del = 1'b1;
				state_d = ST_GAP;
			end
			ST_GAP: begin
				// one gap position per cycle, then advance walk by the length
				cmd.upd_gap = 1'b1;
				if (stat.gap_done) state_d = ST_IDLE;
			end
			ST_BASE: begin
				cmd.upd_base = 1'b1;
				state_d = ST_IDLE;
			end
			ST_RD: begin
				cmd.rd_issue = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_valid && !out_stall) begin
					cmd.out_next = 1'b1;
					if (stat.rd_done) state_d = ST_IDLE;
					else state_d = ST_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

[rtl/core/pfc_dp.sv]
module pfc_dp import pfc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data,
	input logic in_valid,
	input logic [31:0] position,
	input logic reverse_strand,
	input logic mapped,
	input logic [15:0] cigar_length,
	input logic next_is_indel,
	input logic [7:0] base,
	input logic [OffW-1:0] readout_offset,
	input pfc_cmd_t cmd,
	output pfc_stat_t stat,
	output logic out_valid,
	output logic [FeatW-1:0] feature,
	output logic [15:0] value,
	output logic last
);

	logic [31:0] rstart_q, rend_q;
	logic [15:0] maxv_q;
	logic [31:0] walk_q;
	logic active_q, rev_q, anchor_q;
	logic [15:0] left_q;
	logic [15:0] len_q, gi_q;
	logic next_q;
	logic [7:0] base_q;
	logic [OffW-1:0] roff_q;
	logic [FeatW-1:0] rf_q;
	logic [OffW:0] clr_q;

	logic [CountW-1:0] fmem [FeatDepth];
	logic [CountW-1:0] cmem [RegionLen];

	// address computation for updates, clearing and readout, and walk advance
	logic [32:0] upos;
	logic [32:0] d;
	logic uin;
	logic [OffW-1:0] uoff;
	logic [FeatW-1:0] ufeat;
	logic fwe, cwe;
	logic [FeatAddrW-1:0] faddr;
	logic [OffW-1:0] caddr;
	logic [32:0] wsum;
	logic [15:0] adv;
	logic do_adv;

	always_comb begin
		upos = {1'b0, walk_q};
		ufeat = feat_of(base_q, rev_q);
		if (cmd.upd_ins) begin
			upos = {1'b0, walk_q} - 33'd1;
			ufeat = rev_q ? F_INS : F_INS + 4'd7;
		end else if (cmd.upd_del) begin
			upos = {1'b0, walk_q} - 33'd1;
			ufeat = rev_q ? F_DEL : F_DEL + 4'd7;
		end else if (cmd.upd_gap) begin
			upos = {1'b0, walk_q} + {17'd0, gi_q};
			ufeat = rev_q ? F_OTHER : F_OTHER + 4'd7;
		end
		d = upos - {1'b0, rstart_q};
		uin = (upos >= {1'b0, rstart_q}) && (upos <= {1'b0, rend_q})
			&& (d < 33'(RegionLen));
		if ((cmd.upd_ins || cmd.upd_del) && walk_q == 32'd0) uin = 1'b0;
		if (cmd.upd_gap && gi_q == len_q) uin = 1'b0;
		uoff = d[OffW-1:0];
		fwe = uin && (cmd.upd_ins || cmd.upd_del || cmd.upd_gap
			|| (cmd.upd_base && !(left_q == 16'd1 && anchor_q)));
		cwe = uin && cmd.upd_base;
		if (cmd.clr_step) faddr = FeatAddrW'(clr_q[OffW-1:0]) * FeatAddrW'(NumFeat);
		else if (cmd.rd_issue || cmd.out_next)
			faddr = FeatAddrW'(roff_q) * FeatAddrW'(NumFeat) + FeatAddrW'(rf_q);
		else faddr = FeatAddrW'(uoff) * FeatAddrW'(NumFeat) + FeatAddrW'(ufeat);
		caddr = cmd.rd_issue ? roff_q : uoff;
		adv = 16'd0;
		do_adv = 1'b0;
		if (cmd.do_skip && left_q != 16'd0) begin adv = left_q; do_adv = 1'b1; end
		if (cmd.upd_gap && gi_q == len_q) begin adv = len_q; do_adv = 1'b1; end
		if (cmd.upd_base) begin adv = 16'd1; do_adv = 1'b1; end
		wsum = {1'b0, walk_q} + {17'd0, adv};
	end

	// read-modify-write on the counter memories: registered read, write in the next cycle
	logic [CountW-1:0] frd_q, crd_q;
	logic [3:0] fidx_q;
	logic fwe_s1, cwe_s1;
	logic [FeatAddrW-1:0] faddr_s1;
	logic [OffW-1:0] caddr_s1;

	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			fmem[faddr + FeatAddrW'(fidx_q)] <= '0;
			cmem[clr_q[OffW-1:0]] <= '0;
		end else if (cmd.out_next) begin
			if (rf_q == F_COV) cmem[roff_q] <= '0;
			else fmem[faddr] <= '0;
		end else begin
			if (fwe_s1) fmem[faddr_s1] <= (frd_q == '1) ? frd_q : frd_q + 1'b1;
			if (cwe_s1) cmem[caddr_s1] <= (crd_q == '1) ? crd_q : crd_q + 1'b1;
		end
		if (cmd.rd_issue || fwe || cwe) begin
			frd_q <= fmem[faddr];
			crd_q <= cmem[caddr];
		end
		faddr_s1 <= faddr;
		caddr_s1 <= caddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rstart_q <= '0;
			rend_q <= 32'd16383;
			maxv_q <= 16'd255;
			walk_q <= '0;
			active_q <= 1'b0;
			rev_q <= 1'b0;
			anchor_q <= 1'b0;
			left_q <= '0;
			gi_q <= '0;
			clr_q <= '0;
			fidx_q <= '0;
			rf_q <= '0;
			fwe_s1 <= 1'b0;
			cwe_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			fwe_s1 <= fwe;
			cwe_s1 <= cwe;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_START: rstart_q <= cfg_data;
					REG_END: rend_q <= cfg_data;
					REG_MAX: maxv_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (cmd.clr_step) begin
				// one feature word per cycle; coverage cleared with the row
				if (fidx_q == 4'(NumFeat - 1)) begin
					fidx_q <= '0;
					clr_q <= clr_q + 1'b1;
				end else fidx_q <= fidx_q + 1'b1;
			end
			if (cmd.ld_start) begin
				active_q <= mapped;
				if (mapped) begin
					walk_q <= position;
					rev_q <= reverse_strand;
				end
				left_q <= '0;
				anchor_q <= 1'b0;
			end
			if (cmd.ld_cigar) begin
				left_q <= len_q;
				anchor_q <= next_q;
			end
			if (cmd.stop_read) active_q <= 1'b0;
			if (cmd.do_skip) left_q <= '0;
			if (cmd.upd_base) left_q <= left_q - 16'd1;
			if (cmd.upd_del) gi_q <= '0;
			else if (cmd.upd_gap && gi_q != len_q) gi_q <= gi_q + 16'd1;
			if (do_adv) begin
				if (wsum[32]) begin
					walk_q <= '1;
					active_q <= 1'b0;
					left_q <= '0;
				end else walk_q <= wsum[31:0];
			end
			if (cmd.rd_issue) out_valid <= 1'b1;
			if (cmd.out_next) begin
				out_valid <= 1'b0;
				rf_q <= (rf_q == F_COV) ? '0 : rf_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && cmd == '0) begin
			len_q <= cigar_length;
			next_q <= next_is_indel;
			base_q <= base;
			roff_q <= readout_offset;
		end
	end

	assign feature = rf_q;
	assign last = (rf_q == F_COV);
	always_comb begin
		if (rf_q == F_COV) value = crd_q;
		else value = (frd_q > maxv_q) ? maxv_q : frd_q;
	end

	assign stat.clr_done = cmd.clr_step && clr_q[OffW-1:0] == OffW'(RegionLen - 1)
		&& fidx_q == 4'(NumFeat - 1);
	assign stat.active = active_q;
	assign stat.bases_pend = (left_q != 16'd0);
	assign stat.past_end = (walk_q > rend_q);
	assign stat.gap_done = (gi_q == len_q);
	assign stat.rd_done = (rf_q == F_COV);

	`include "pileup_feature_counter_assert.svh"
	`PFC_ASSERT_IMPL(a_last_cov, out_valid && last, feature == F_COV, "last off coverage")
	`PFC_ASSERT_IMPL(a_ld_left, cmd.ld_cigar, ##1 left_q == $past(len_q), "bases not loaded")
	`PFC_ASSERT_IMPL(a_base_left, cmd.upd_base, left_q != 16'd0, "base with none left")

endmodule

[rtl/core/pileup_feature_counter.sv]
// channel  | valid      | stall      | payload
// in       | in_valid   | in_stall   | op .. readout_offset
// out      | out_valid  | out_stall  | feature, value, last
// Start items, and items for an inactive read, end in the idle state. Cigars
// pass skip and cigar states, then the insert state (I) or delete and gap
// states (D/N/P); bases the base state. Readout gives 15 beats via ST_RD/ST_OUT.
// After reset a clearing pass over every counter runs before the first item.
// in_stall is high whenever the controller is busy; out_stall holds the beat.
module pileup_feature_counter import pfc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] op,
	input logic [31:0] position,
	input logic reverse_strand,
	input logic mapped,
	input logic [3:0] cigar_kind,
	input logic [15:0] cigar_length,
	input logic next_is_indel,
	input logic [7:0] base,
	input logic [13:0] readout_offset,
	output logic out_valid,
	input logic out_stall,
	output logic [3:0] feature,
	output logic [15:0] value,
	output logic last
);

	pfc_cmd_t cmd;
	pfc_stat_t stat;
	logic [3:0] kind_q;

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) kind_q <= cigar_kind;
	end

	pfc_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .op, .cigar_kind(kind_q),
		.out_stall, .out_valid, .cmd, .stat
	);

	pfc_dp u_dp (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid(in_valid && !in_stall), .position, .reverse_strand, .mapped,
		.cigar_length, .next_is_indel, .base, .readout_offset,
		.cmd, .stat, .out_valid, .feature, .value, .last
	);

endmodule
